/* design/ita_pkg.sv */
`timescale 1ns / 1ps

package ita_pkg;

  // Default width of the signed input value.
  localparam int ITA_VALUE_BITS = 32;

  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // Operation codes for the shared BCD unit.
  typedef logic [1:0] ita_op_t;
  localparam ita_op_t OP_HOLD  = 2'd0;
  localparam ita_op_t OP_LOAD  = 2'd1;  // take a new magnitude, clear BCD
  localparam ita_op_t OP_STEP  = 2'd2;  // one add-3 / shift-left step
  localparam ita_op_t OP_DIGIT = 2'd3;  // shift BCD up by one digit

endpackage

/* design/int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// Channel | Direction | Ports                       | Handshake
// in      | input     | in_value                    | in_valid / in_stall
// out     | output    | out_character, out_last     | out_valid / out_stall
//
// One request is accepted, converted by double-dabble in the shared BCD unit,
// has its leading zero digits dropped one at a time, then sends one character
// per cycle while out_stall is low.
// in_stall is high from acceptance until the last character is loaded into
// the output register. rst_n is synchronous, active low, and clears control.
// out_stall only delays characters; nothing is lost or repeated.

module int_to_decimal_ascii #(
  parameter int VALUE_BITS = ita_pkg::ITA_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ita_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last
);
  import ita_pkg::*;

  localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;  // >= digits of 2^(VALUE_BITS-1)
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int DCNT_W = $clog2(DIGITS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;  // binary to BCD, one bit a cycle
  localparam logic [2:0] S_SKIP  = 3'd2;  // drop leading zero digits
  localparam logic [2:0] S_SIGN  = 3'd3;  // emit '-'
  localparam logic [2:0] S_DIGIT = 3'd4;  // emit digits, most significant first

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              neg_r, neg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  ita_op_t               op;
  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [3:0]            top_digit;
  logic                  accept;
  logic                  advance;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // output register may take a new character
  assign advance  = !out_valid_r || !out_stall;

  // magnitude in unsigned arithmetic: the most negative value maps to 2^(N-1)
  assign mag = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;

  assign top_digit = bcd[BCD_W-1 -: 4];

  ita_dabble #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dabble (
    .clk (clk),
    .op  (op),
    .mag (mag),
    .bcd (bcd)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dcnt_nxt      = dcnt_r;
    neg_nxt       = neg_r;
    op            = OP_HOLD;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op        = OP_LOAD;
          neg_nxt   = in_value[VALUE_BITS-1];
          cnt_nxt   = CNT_W'(VALUE_BITS);
          dcnt_nxt  = DCNT_W'(DIGITS);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        op      = OP_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // keep at least one digit so zero prints as '0'
        if (top_digit == 4'd0 && dcnt_r != DCNT_W'(1)) begin
          op       = OP_DIGIT;
          dcnt_nxt = dcnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {3'd0, top_digit};
          out_last_nxt  = (dcnt_r == DCNT_W'(1));
          op            = OP_DIGIT;
          dcnt_nxt      = dcnt_r - 1'b1;
          if (dcnt_r == DCNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    dcnt_r     <= dcnt_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

/* design/ita_dabble.sv */
`timescale 1ns / 1ps

module ita_dabble #(
  parameter int VALUE_BITS = ita_pkg::ITA_VALUE_BITS
) (
  input  logic                                     clk,
  input  ita_pkg::ita_op_t                         op,
  input  logic [VALUE_BITS-1:0]                    mag,
  output logic [((VALUE_BITS*3)/10+1)*4-1:0]       bcd
);
  import ita_pkg::*;

  localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int BCD_W  = DIGITS * 4;

  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      bcd_adj;

  // add 3 to every digit of 5 or more, digits are independent
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    unique case (op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        bin_nxt = mag;
        bcd_nxt = '0;
      end
      OP_STEP: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      end
      OP_DIGIT: begin
        bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd = bcd_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ita_pkg::*;

  localparam int VB = ITA_VALUE_BITS;
  // Slowest run is well under this: ~525 requests, each at most 11 characters
  // behind a heavily stalling receiver plus the conversion and sender gaps.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Drain time after the last expected character (one full conversion).
  localparam int TAIL_CYCLES = VB + 24;
  localparam int PHASE_ITEMS = 167;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_exp_t;

  // Holds the characters still owed by the block, oldest first.
  class digit_scoreboard;
    char_exp_t expected_chars[$];
    int        mismatches = 0;

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Decimal text of one accepted request: optional minus, then digits.
    function void note_request(logic signed [VB-1:0] value);
      logic [VB-1:0] raw;
      logic [VB-1:0] mag;
      logic [3:0]    digits[24];
      int            nd;
      raw = value;
      // unsigned negate, so the most negative value maps onto 2^(VB-1)
      mag = raw[VB-1] ? (~raw + 1'b1) : raw;
      nd  = 0;
      do begin
        digits[nd] = 4'(mag % 10);
        mag        = mag / 10;
        nd++;
      end while (mag != 0);
      if (raw[VB-1]) begin
        expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
      end
      for (int i = nd - 1; i >= 0; i--) begin
        expected_chars.push_back('{ch: CHAR_W'(CHAR_ZERO + digits[i]), last: (i == 0)});
      end
    endfunction

    task check_char(logic [CHAR_W-1:0] ch, logic last);
      char_exp_t exp_c;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b", ch, last));
      end else begin
        exp_c = expected_chars.pop_front();
        if (ch !== exp_c.ch)
          report_mismatch($sformatf("character got 0x%02h want 0x%02h", ch, exp_c.ch));
        if (last !== exp_c.last)
          report_mismatch($sformatf("last got %0b want %0b (char 0x%02h)",
                                    last, exp_c.last, exp_c.ch));
      end
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Block hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic signed [VB-1:0] in_value  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    out_character;
  logic                 out_last;

  int unsigned in_idle_pct  = 0;   // chance the sender holds off per cycle
  int unsigned out_stall_pct = 0;  // chance the receiver stalls per cycle
  int unsigned cycles = 0;

  digit_scoreboard sb = new();

  int_to_decimal_ascii #(.VALUE_BITS(VB)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung block or a lost character ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver back-pressure, a fresh coin every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Monitors sample the values that stood at the edge, before any update.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_value);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_char(out_character, out_last);
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge the request is taken.
  // in_valid gets one assignment per step, so back-to-back requests keep it up.
  // ---------------------------------------------------------------------------
  task send_value(logic signed [VB-1:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random value: full range, a chosen digit count, tiny, or near the ends.
  function automatic logic signed [VB-1:0] pick_value();
    logic [VB-1:0] mag;
    int unsigned   nd;
    int unsigned   pow10;
    case ($urandom_range(3))
      0: return VB'($urandom);
      1: begin
        nd = $urandom_range(1, 10);
        if (nd == 10) begin
          mag = VB'($urandom) & {1'b0, {(VB-1){1'b1}}};
        end else begin
          pow10 = 1;
          repeat (nd) pow10 = pow10 * 10;
          mag = VB'($urandom % pow10);
        end
        return $urandom_range(1) ? -$signed(mag) : $signed(mag);
      end
      2: return VB'($signed($urandom_range(40)) - 20);
      default: begin
        mag = VB'($urandom_range(15));
        if ($urandom_range(1))
          return {1'b0, {(VB-1){1'b1}}} - mag;  // just below the top
        return {1'b1, {(VB-1){1'b0}}} + mag;    // most negative and neighbors
      end
    endcase
  endfunction

  task run_random(int n);
    repeat (n) send_value(pick_value());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [VB-1:0] directed[$];
    directed = '{
      VB'(0), VB'(1), -VB'(1), VB'(9), VB'(10), -VB'(10), VB'(99), VB'(100),
      -VB'(100), VB'(12345), -VB'(987654), VB'(999_999_999), -VB'(999_999_999),
      VB'(1_000_000_000), -VB'(1_000_000_000),
      {1'b0, {(VB-1){1'b1}}},                   // largest positive
      {1'b1, {(VB-1){1'b0}}},                   // most negative, no overflow
      {1'b1, {(VB-2){1'b0}}, 1'b1},             // one above most negative
      {1'b0, {(VB-2){1'b1}}, 1'b0},
      VB'(32'h5555_5555), VB'(32'hAAAA_AAAA), VB'(32'h8000_0001),
      VB'(2_147_483_640)
    };

    // reset held low while the repeat loop waits, released with a nonblocking write at an edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // phase 1: light sender idling, heavy receiver stall
    in_idle_pct   = 15;
    out_stall_pct = 67;
    foreach (directed[i]) send_value(directed[i]);
    run_random(PHASE_ITEMS);

    // phase 2: roles swapped
    in_idle_pct   = 67;
    out_stall_pct = 15;
    run_random(PHASE_ITEMS);

    // phase 3: full rate on both sides
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_random(PHASE_ITEMS);
    in_valid <= 1'b0;

    // drain: every owed character, then a full conversion time for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
